// ===== hw/rtl/capq_pkg.sv =====
// Shared types, codes and constants of the credit admission print queue.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package capq_pkg;

    // Sizing
    localparam int QUEUE_DEPTH  = 64;
    localparam int SIZE_W       = 16;
    localparam int NUM_W        = 16;
    localparam int WCNT_W       = 7;
    localparam int ENTRY_W      = NUM_W + SIZE_W;
    localparam int MAX_RESULTS  = 3;
    localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
    localparam int APB_ADDR_W   = 2;
    localparam int APB_DATA_W   = 32;

    // Reset values
    localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(1000);
    localparam logic [NUM_W-1:0]  NUMBER_RESET   = NUM_W'(1);

    // Register map
    localparam logic [APB_ADDR_W-1:0] ADDR_BUFFER_CAPACITY = APB_ADDR_W'(0);

    // Input operation codes
    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Result event codes
    typedef enum logic [2:0] {
        EV_ACCEPTED   = 3'd0,
        EV_QUEUE_FULL = 3'd1,
        EV_CANCELLED  = 3'd2,
        EV_ADMITTED   = 3'd3,
        EV_STARTED    = 3'd4,
        EV_COMPLETED  = 3'd5
    } capq_event_t;

    // One result item
    typedef struct packed {
        capq_event_t         event_res;
        logic [NUM_W-1:0]    job_number;
        logic [SIZE_W-1:0]   event_size;
        logic [SIZE_W-1:0]   free_credits;
        logic [WCNT_W-1:0]   waiting_count;
        logic                last;
    } capq_result_t;

    // Capacity register write strobe
    typedef struct packed {
        logic              we;
        logic [SIZE_W-1:0] data;
    } capq_cfg_wr_t;

    // Results produced by one accepted item, packed in order
    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        capq_result_t [MAX_RESULTS-1:0]    item;
    } capq_push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/capq_in_if.sv =====
// Input channel of the print queue: valid/ready handshake with a job item.
// Depends on capq_pkg for field widths.
`default_nettype none

interface capq_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [capq_pkg::SIZE_W-1:0] job_size;

    modport source (output valid, output mode, output job_size, input ready);
    modport sink   (input valid, input mode, input job_size, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/capq_out_if.sv =====
// Output channel of the print queue: valid/ready handshake with one event.
// Depends on capq_pkg for field widths and the event type.
`default_nettype none

interface capq_out_if;
    logic                        valid;
    logic                        ready;
    capq_pkg::capq_event_t       event_res;
    logic [capq_pkg::NUM_W-1:0]  job_number;
    logic [capq_pkg::SIZE_W-1:0] event_size;
    logic [capq_pkg::SIZE_W-1:0] free_credits;
    logic [capq_pkg::WCNT_W-1:0] waiting_count;
    logic                        last;

    modport source (output valid, output event_res, output job_number, output event_size,
                    output free_credits, output waiting_count, output last, input ready);
    modport sink   (input valid, input event_res, input job_number, input event_size,
                    input free_credits, input waiting_count, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/capq_engine.sv =====
// Queue state, both job FIFOs and the single-pass submit/tick datapath.
// Depends on capq_pkg; feeds the result buffer with up to three events per item.
`default_nettype none

module capq_engine #(
    parameter int QUEUE_DEPTH = capq_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic                          mode,
    input  wire logic [capq_pkg::SIZE_W-1:0]   job_size,
    input  wire capq_pkg::capq_cfg_wr_t        cfg,
    output      logic [capq_pkg::SIZE_W-1:0]   capacity,
    output      capq_pkg::capq_push_t          push
);

    localparam int SIZE_W  = capq_pkg::SIZE_W;
    localparam int NUM_W   = capq_pkg::NUM_W;
    localparam int WCNT_W  = capq_pkg::WCNT_W;
    localparam int ENTRY_W = capq_pkg::ENTRY_W;
    localparam int NRES    = capq_pkg::MAX_RESULTS;
    localparam int RCW     = capq_pkg::RES_CNT_W;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    // Job FIFO storage
    logic [SIZE_W-1:0]  wait_mem  [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] ready_mem [QUEUE_DEPTH];
    logic [SIZE_W-1:0]  wait_rdata_reg;
    logic [ENTRY_W-1:0] ready_rdata_reg;

    // Control state
    logic [PTR_W-1:0]  wait_head_reg,  wait_head_next;
    logic [PTR_W-1:0]  wait_tail_reg,  wait_tail_next;
    logic [CNT_W-1:0]  wait_count_reg, wait_count_next;
    logic [PTR_W-1:0]  ready_head_reg,  ready_head_next;
    logic [PTR_W-1:0]  ready_tail_reg,  ready_tail_next;
    logic [CNT_W-1:0]  ready_count_reg, ready_count_next;
    logic [SIZE_W-1:0] free_reg,     free_next;
    logic [SIZE_W-1:0] capacity_reg, capacity_next;
    logic              busy_reg,     busy_next;
    logic [SIZE_W-1:0] left_reg,     left_next;
    logic [NUM_W-1:0]  pnum_reg,     pnum_next;
    logic [NUM_W-1:0]  next_num_reg, next_num_next;

    // Datapath terms
    logic               is_submit, is_tick, wait_full, sub_push;
    logic [SIZE_W-1:0]  left_dec, free_drain, free_adm, head_size;
    logic               drained, done, busy_mid;
    logic               too_big, cancel, admit, pop_wait, start;
    logic [CNT_W-1:0]   wait_cnt_after;
    logic [ENTRY_W-1:0] admit_entry, start_entry;
    logic [SIZE_W-1:0]  cfg_free;
    logic [SIZE_W:0]    cfg_sum;
    logic [SIZE_W-1:0]  cfg_delta;
    capq_pkg::capq_result_t [NRES-1:0] ev;
    logic [NRES-1:0]                   ev_v;

    assign capacity = capacity_reg;

    // Decode the item
    assign is_submit = step && (mode == capq_pkg::MODE_SUBMIT);
    assign is_tick   = step && (mode == capq_pkg::MODE_TICK);
    assign wait_full = (wait_count_reg == FULL_CNT);
    assign sub_push  = is_submit && !wait_full;

    // Drain one KB of the printing job
    assign drained    = busy_reg && (left_reg != '0);
    assign left_dec   = drained ? SIZE_W'(left_reg - 1'b1) : left_reg;
    assign free_drain = (drained && (free_reg < capacity_reg)) ? SIZE_W'(free_reg + 1'b1)
                                                               : free_reg;
    assign done       = is_tick && busy_reg && (left_dec == '0);
    assign busy_mid   = busy_reg && (left_dec != '0);

    // Check the head waiting job
    assign head_size      = wait_rdata_reg;
    assign too_big        = head_size > capacity_reg;
    assign cancel         = is_tick && (wait_count_reg != '0) && too_big;
    assign admit          = is_tick && (wait_count_reg != '0) && !too_big &&
                            (free_drain >= head_size) && (ready_count_reg != FULL_CNT);
    assign pop_wait       = cancel || admit;
    assign free_adm       = admit ? SIZE_W'(free_drain - head_size) : free_drain;
    assign wait_cnt_after = pop_wait ? CNT_W'(wait_count_reg - 1'b1) : wait_count_reg;
    assign admit_entry    = {next_num_reg, head_size};

    // Start the oldest admitted job; bypass the job admitted in this tick
    assign start       = is_tick && !busy_mid && ((ready_count_reg != '0) || admit);
    assign start_entry = (ready_count_reg != '0) ? ready_rdata_reg : admit_entry;

    // Capacity write moves the free credits by the change, floored and saturated
    always_comb
    begin
        cfg_sum   = '0;
        cfg_delta = '0;
        if (cfg.data >= capacity_reg)
        begin
            cfg_sum  = {1'b0, free_reg} + {1'b0, SIZE_W'(cfg.data - capacity_reg)};
            cfg_free = cfg_sum[SIZE_W] ? '1 : cfg_sum[SIZE_W-1:0];
        end
        else
        begin
            cfg_delta = SIZE_W'(capacity_reg - cfg.data);
            cfg_free  = (free_reg > cfg_delta) ? SIZE_W'(free_reg - cfg_delta) : '0;
        end
    end

    // Next state
    always_comb
    begin
        wait_head_next   = wait_head_reg;
        wait_tail_next   = wait_tail_reg;
        wait_count_next  = wait_count_reg;
        ready_head_next  = ready_head_reg;
        ready_tail_next  = ready_tail_reg;
        ready_count_next = ready_count_reg;
        free_next        = free_reg;
        capacity_next    = capacity_reg;
        busy_next        = busy_reg;
        left_next        = left_reg;
        pnum_next        = pnum_reg;
        next_num_next    = next_num_reg;
        if (cfg.we)
        begin
            capacity_next = cfg.data;
            free_next     = cfg_free;
        end
        else if (sub_push)
        begin
            wait_tail_next  = advance(wait_tail_reg);
            wait_count_next = CNT_W'(wait_count_reg + 1'b1);
        end
        else if (is_tick)
        begin
            free_next       = free_adm;
            wait_count_next = wait_cnt_after;
            if (pop_wait)
            begin
                wait_head_next = advance(wait_head_reg);
                next_num_next  = NUM_W'(next_num_reg + 1'b1);
            end
            if (admit)
                ready_tail_next = advance(ready_tail_reg);
            if (start)
                ready_head_next = advance(ready_head_reg);
            ready_count_next = CNT_W'(ready_count_reg + CNT_W'(admit) - CNT_W'(start));
            if (start)
            begin
                busy_next = 1'b1;
                left_next = start_entry[SIZE_W-1:0];
                pnum_next = start_entry[ENTRY_W-1:SIZE_W];
            end
            else
            begin
                busy_next = busy_mid;
                left_next = left_dec;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_head_reg   <= '0;
            wait_tail_reg   <= '0;
            wait_count_reg  <= '0;
            ready_head_reg  <= '0;
            ready_tail_reg  <= '0;
            ready_count_reg <= '0;
            free_reg        <= capq_pkg::CAPACITY_RESET;
            capacity_reg    <= capq_pkg::CAPACITY_RESET;
            busy_reg        <= 1'b0;
            left_reg        <= '0;
            pnum_reg        <= '0;
            next_num_reg    <= capq_pkg::NUMBER_RESET;
        end
        else
        begin
            wait_head_reg   <= wait_head_next;
            wait_tail_reg   <= wait_tail_next;
            wait_count_reg  <= wait_count_next;
            ready_head_reg  <= ready_head_next;
            ready_tail_reg  <= ready_tail_next;
            ready_count_reg <= ready_count_next;
            free_reg        <= free_next;
            capacity_reg    <= capacity_next;
            busy_reg        <= busy_next;
            left_reg        <= left_next;
            pnum_reg        <= pnum_next;
            next_num_reg    <= next_num_next;
        end
    end

    // Waiting FIFO: write at tail, keep the entry at the next head registered
    always_ff @(posedge clk)
    begin
        if (sub_push)
            wait_mem[wait_tail_reg] <= job_size;
        if (sub_push && (wait_tail_reg == wait_head_next))
            wait_rdata_reg <= job_size;
        else
            wait_rdata_reg <= wait_mem[wait_head_next];
    end

    // Ready FIFO: same scheme, entries carry number and size
    always_ff @(posedge clk)
    begin
        if (admit)
            ready_mem[ready_tail_reg] <= admit_entry;
        if (admit && (ready_tail_reg == ready_head_next))
            ready_rdata_reg <= admit_entry;
        else
            ready_rdata_reg <= ready_mem[ready_head_next];
    end

    // Build the candidate events in their order
    always_comb
    begin
        ev   = '0;
        ev_v = '0;
        if (is_submit)
        begin
            ev_v[0]               = 1'b1;
            ev[0].event_res       = wait_full ? capq_pkg::EV_QUEUE_FULL
                                              : capq_pkg::EV_ACCEPTED;
            ev[0].job_number      = wait_full ? '0 : NUM_W'(next_num_reg + wait_count_reg);
            ev[0].event_size      = job_size;
            ev[0].free_credits    = free_reg;
            ev[0].waiting_count   = wait_full ? WCNT_W'(wait_count_reg)
                                              : WCNT_W'(wait_count_reg + 1'b1);
        end
        else
        begin
            ev_v[0]               = done;
            ev[0].event_res       = capq_pkg::EV_COMPLETED;
            ev[0].job_number      = pnum_reg;
            ev[0].event_size      = '0;
            ev[0].free_credits    = free_drain;
            ev[0].waiting_count   = WCNT_W'(wait_count_reg);
        end
        ev_v[1]             = pop_wait;
        ev[1].event_res     = cancel ? capq_pkg::EV_CANCELLED : capq_pkg::EV_ADMITTED;
        ev[1].job_number    = next_num_reg;
        ev[1].event_size    = head_size;
        ev[1].free_credits  = free_adm;
        ev[1].waiting_count = WCNT_W'(wait_cnt_after);
        ev_v[2]             = start;
        ev[2].event_res     = capq_pkg::EV_STARTED;
        ev[2].job_number    = start_entry[ENTRY_W-1:SIZE_W];
        ev[2].event_size    = start_entry[SIZE_W-1:0];
        ev[2].free_credits  = free_adm;
        ev[2].waiting_count = WCNT_W'(wait_cnt_after);
    end

    // Pack the present events and mark the final one
    always_comb
    begin
        logic [RCW-1:0] idx;
        idx  = '0;
        push = '0;
        for (int i = 0; i < NRES; i++)
        begin
            if (ev_v[i])
            begin
                push.item[idx] = ev[i];
                idx            = RCW'(idx + 1'b1);
            end
        end
        push.count = idx;
        if (idx != '0)
            push.item[RCW'(idx - 1'b1)].last = 1'b1;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/capq_result_buf.sv =====
// Four-entry result buffer: takes up to three events at once, sends one per transfer.
// Depends on capq_pkg and the output channel interface.
`default_nettype none

module capq_result_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire capq_pkg::capq_push_t push,
    output      logic                 can_accept,
    capq_out_if.source                res_out
);

    localparam int DEPTH = capq_pkg::MAX_RESULTS + 1;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NRES  = capq_pkg::MAX_RESULTS;

    capq_pkg::capq_result_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    capq_pkg::capq_result_t head;

    // Room for a full burst while the oldest result may still stall
    assign can_accept = (count_reg <= CNT_W'(1));

    assign head                  = slot_reg[rd_ptr_reg];
    assign res_out.valid         = (count_reg != '0);
    assign res_out.event_res     = head.event_res;
    assign res_out.job_number    = head.job_number;
    assign res_out.event_size    = head.event_size;
    assign res_out.free_credits  = head.free_credits;
    assign res_out.waiting_count = head.waiting_count;
    assign res_out.last          = head.last;
    assign pop                   = res_out.valid && res_out.ready;

    // Advance pointers and occupancy
    assign wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push.count));
    assign rd_ptr_next = PTR_W'(rd_ptr_reg + PTR_W'(pop));
    assign count_next  = CNT_W'(count_reg + CNT_W'(push.count) - CNT_W'(pop));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the burst in consecutive slots
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NRES; j++)
        begin
            if (j < int'(push.count))
                slot_reg[PTR_W'(wr_ptr_reg + PTR_W'(j))] <= push.item[j];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/credit_admission_print_queue.sv =====
// Credit admission print queue. Each accepted item is worked in the cycle it is
// taken: a submit (mode 0) yields one result, a tick (mode 1) yields zero to three
// (completed, cancelled or admitted, started), all written at once into a four-entry
// result buffer that sends one result per cycle while the output is ready. The input
// takes one item per cycle while that buffer holds at most one result, so submits run
// at one item per cycle; the output port sets the pace. The waiting and ready FIFOs
// are QUEUE_DEPTH-entry memories whose head entries are kept registered; they need no
// clearing after reset. buffer_capacity sits at byte address 0 of the APB port; the
// user must write it only while the block is idle, which the block does not enforce.
// Depends on capq_pkg, capq_in_if, capq_out_if, capq_engine and capq_result_buf.
`default_nettype none

module credit_admission_print_queue #(
    parameter int QUEUE_DEPTH = capq_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [capq_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [capq_pkg::APB_DATA_W-1:0]   pwdata,
    output      logic [capq_pkg::APB_DATA_W-1:0]   prdata,
    output      logic                              pready,
    capq_in_if.sink                                job_in,
    capq_out_if.source                             res_out
);

    capq_pkg::capq_cfg_wr_t           cfg;
    capq_pkg::capq_push_t             push;
    logic [capq_pkg::SIZE_W-1:0]      capacity;
    logic                             can_accept;
    logic                             step;

    // Register access
    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite && pready &&
                      (paddr == capq_pkg::ADDR_BUFFER_CAPACITY);
    assign cfg.data = pwdata[capq_pkg::SIZE_W-1:0];
    assign prdata   = (paddr == capq_pkg::ADDR_BUFFER_CAPACITY)
                      ? capq_pkg::APB_DATA_W'(capacity) : '0;

    // Input transfer
    assign job_in.ready = can_accept;
    assign step         = job_in.valid && job_in.ready;

    capq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .mode     (job_in.mode),
        .job_size (job_in.job_size),
        .cfg      (cfg),
        .capacity (capacity),
        .push     (push)
    );

    capq_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .can_accept (can_accept),
        .res_out    (res_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/capq_checker.sv =====
// Port-level checks on the result channel of the print queue, bound to the top level.
// Depends on capq_pkg for the event codes.
`default_nettype none

module capq_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [2:0]                  event_res,
    input wire logic [capq_pkg::NUM_W-1:0]  job_number,
    input wire logic [capq_pkg::SIZE_W-1:0] event_size,
    input wire logic                        last
);

    // A stalled result holds its contents
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({event_res, job_number, event_size, last}))
        else $error("stalled result changed");

    // The results of one item leave without gaps
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("gap inside a result burst");

    // A rejected submit carries no job number and ends its item
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == capq_pkg::EV_QUEUE_FULL) |-> (job_number == '0) && last)
        else $error("queue full result malformed");

    // Completion reports no size
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == capq_pkg::EV_COMPLETED) |-> (event_size == '0))
        else $error("completion with nonzero size");

endmodule

bind credit_admission_print_queue capq_checker u_capq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .event_res  (res_out.event_res),
    .job_number (res_out.job_number),
    .event_size (res_out.event_size),
    .last       (res_out.last)
);

`default_nettype wire
